// ----- rtl/core/cvr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvr_pkg: shared types, constants and tables for the cube rotation remapper
// Holds the per-rotation axis selection and the rotation quaternions (Q2.14).
// ----------------------------------------------------------------------------
package cvr_pkg;

    // Volume geometry
    localparam int MAX_EDGE  = 256;
    localparam int EDGE_W    = $clog2(MAX_EDGE + 1);
    localparam int COORD_W   = 8;
    localparam int PART_W    = 16;
    localparam int ADDR_W    = 24;
    localparam int VALUE_W   = 32;
    localparam int QUAT_W    = 16;
    localparam int ROT_W     = 5;
    localparam int NUM_ROT   = 24;

    // Configuration register indexes
    localparam logic CFG_EDGE_SIZE = 1'b0;
    localparam logic CFG_ROTATION  = 1'b1;

    // Quaternion constants, Q2.14
    localparam logic signed [QUAT_W-1:0] Q_ZERO = 16'sd0;
    localparam logic signed [QUAT_W-1:0] Q_ONE  = 16'sd16384;
    localparam logic signed [QUAT_W-1:0] Q_HALF = 16'sd8192;
    localparam logic signed [QUAT_W-1:0] Q_SQ   = 16'sd11585;
    localparam logic signed [QUAT_W-1:0] Q_NHALF = -16'sd8192;
    localparam logic signed [QUAT_W-1:0] Q_NSQ   = -16'sd11585;

    // Source axis select: bits 1:0 pick the axis, bit 2 mirrors it
    typedef enum logic [2:0] {
        AX = 3'd0,
        AY = 3'd1,
        AZ = 3'd2,
        MX = 3'd4,
        MY = 3'd5,
        MZ = 3'd6
    } axis_code_t;

    typedef struct packed {
        axis_code_t cx;
        axis_code_t cy;
        axis_code_t cz;
    } axis_sel_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
    } quat_t;

    // Remapped coordinates of one voxel plus range flag
    typedef struct packed {
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [COORD_W-1:0] dz;
        logic               bad;
    } coord_t;

    // Fold rotation codes above the table onto identity
    function automatic logic [ROT_W-1:0] rot_clamp(input logic [ROT_W-1:0] r);
        logic [ROT_W-1:0] res;
        res = (r > ROT_W'(NUM_ROT - 1)) ? '0 : r;
        return res;
    endfunction

    // Source axis for destination x, y, z per rotation
    function automatic axis_sel_t rot_axes(input logic [ROT_W-1:0] r);
        axis_sel_t s;
        unique case (r)
            5'd0:    s = '{AX, AY, AZ};
            5'd1:    s = '{AX, MY, MZ};
            5'd2:    s = '{MX, AY, MZ};
            5'd3:    s = '{MX, MY, AZ};
            5'd4:    s = '{MZ, MY, MX};
            5'd5:    s = '{MZ, AY, AX};
            5'd6:    s = '{AZ, MY, AX};
            5'd7:    s = '{AZ, AY, MX};
            5'd8:    s = '{AZ, AX, AY};
            5'd9:    s = '{AZ, MX, MY};
            5'd10:   s = '{MZ, AX, MY};
            5'd11:   s = '{MZ, MX, AY};
            5'd12:   s = '{MY, MX, MZ};
            5'd13:   s = '{MY, AX, AZ};
            5'd14:   s = '{AY, MX, AZ};
            5'd15:   s = '{AY, AX, MZ};
            5'd16:   s = '{AY, AZ, AX};
            5'd17:   s = '{AY, MZ, MX};
            5'd18:   s = '{MY, AZ, MX};
            5'd19:   s = '{MY, MZ, AX};
            5'd20:   s = '{MX, MZ, MY};
            5'd21:   s = '{MX, AZ, AY};
            5'd22:   s = '{AX, MZ, AY};
            5'd23:   s = '{AX, AZ, MY};
            default: s = '{AX, AY, AZ};
        endcase
        return s;
    endfunction

    // Unit quaternion per rotation, w x y z
    function automatic quat_t rot_quat(input logic [ROT_W-1:0] r);
        quat_t q;
        unique case (r)
            5'd0:    q = '{Q_ONE,   Q_ZERO,  Q_ZERO,  Q_ZERO};
            5'd1:    q = '{Q_ZERO,  Q_ONE,   Q_ZERO,  Q_ZERO};
            5'd2:    q = '{Q_ZERO,  Q_ZERO,  Q_ONE,   Q_ZERO};
            5'd3:    q = '{Q_ZERO,  Q_ZERO,  Q_ZERO,  Q_ONE};
            5'd4:    q = '{Q_ZERO,  Q_SQ,    Q_ZERO,  Q_NSQ};
            5'd5:    q = '{Q_NSQ,   Q_ZERO,  Q_SQ,    Q_ZERO};
            5'd6:    q = '{Q_ZERO,  Q_NSQ,   Q_ZERO,  Q_NSQ};
            5'd7:    q = '{Q_SQ,    Q_ZERO,  Q_SQ,    Q_ZERO};
            5'd8:    q = '{Q_HALF,  Q_HALF,  Q_HALF,  Q_HALF};
            5'd9:    q = '{Q_NHALF, Q_HALF,  Q_NHALF, Q_HALF};
            5'd10:   q = '{Q_NHALF, Q_HALF,  Q_HALF,  Q_NHALF};
            5'd11:   q = '{Q_NHALF, Q_NHALF, Q_HALF,  Q_HALF};
            5'd12:   q = '{Q_ZERO,  Q_SQ,    Q_NSQ,   Q_ZERO};
            5'd13:   q = '{Q_NSQ,   Q_ZERO,  Q_ZERO,  Q_NSQ};
            5'd14:   q = '{Q_SQ,    Q_ZERO,  Q_ZERO,  Q_NSQ};
            5'd15:   q = '{Q_ZERO,  Q_SQ,    Q_SQ,    Q_ZERO};
            5'd16:   q = '{Q_NHALF, Q_HALF,  Q_HALF,  Q_HALF};
            5'd17:   q = '{Q_NHALF, Q_NHALF, Q_NHALF, Q_HALF};
            5'd18:   q = '{Q_NHALF, Q_HALF,  Q_NHALF, Q_NHALF};
            5'd19:   q = '{Q_NHALF, Q_NHALF, Q_HALF,  Q_NHALF};
            5'd20:   q = '{Q_ZERO,  Q_ZERO,  Q_SQ,    Q_NSQ};
            5'd21:   q = '{Q_ZERO,  Q_ZERO,  Q_SQ,    Q_SQ};
            5'd22:   q = '{Q_NSQ,   Q_NSQ,   Q_ZERO,  Q_ZERO};
            5'd23:   q = '{Q_SQ,    Q_NSQ,   Q_ZERO,  Q_ZERO};
            default: q = '{Q_ONE,   Q_ZERO,  Q_ZERO,  Q_ZERO};
        endcase
        return q;
    endfunction

endpackage

// ----- rtl/core/cube_volume_rotation_remap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_volume_rotation_remap: voxel destination address for cube rotations
// Remaps one voxel per beat to its rotated linear address and tags it with
// the rotation quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one voxel per beat: value and x, y, z coordinates.
//   m_axis returns one beat per voxel: destination address z*n*n+y*n+x after
//   the selected rotation, the value unchanged and the quaternion (Q2.14);
//   tuser flags a coordinate at or beyond the edge (address then reads 0).
//   cfg_we/cfg_index/cfg_data write edge_size (index 0) and rotation
//   (index 1); write them only while no beat is in flight.
// Timing:
//   Three register stages: input, after the first multiply (dz*n+dy), and
//   the result register after the second multiply. A beat passes these in
//   order to m_axis; one beat per cycle sustained while m_axis_tready is high.
// Reset:
//   rst_n clears all stage valid flags; edge_size returns to 256 and
//   rotation to 0 (identity).
// Stall:
//   A stalled m_axis holds its beat; the stages behind fill in turn and
//   s_axis_tready drops only when all three stages are occupied.
// ----------------------------------------------------------------------------
module cube_volume_rotation_remap
    import cvr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    // configuration write port
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [8:0]    cfg_data,
    // input voxel stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [55:0]   s_axis_tdata,   // voxel_value[31:0], pos_x, pos_y, pos_z
    // output stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [119:0]  m_axis_tdata,   // dest_address[23:0], moved_value[31:0],
                                          // quat_w, quat_x, quat_y, quat_z
    output logic          m_axis_tuser    // out_of_range
);

    // Configuration registers
    logic [EDGE_W-1:0] edge_size_reg;
    logic [ROT_W-1:0]  rotation_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_size_reg <= EDGE_W'(MAX_EDGE);
            rotation_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EDGE_SIZE: edge_size_reg <= cfg_data[EDGE_W-1:0];
                CFG_ROTATION:  rotation_reg  <= cfg_data[ROT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Effective edge and rotation
    logic [EDGE_W-1:0] edge_n;
    logic [ROT_W-1:0]  rot_eff;

    always_comb
    begin
        priority if (edge_size_reg == '0)
            edge_n = EDGE_W'(1);
        else if (edge_size_reg > EDGE_W'(MAX_EDGE))
            edge_n = EDGE_W'(MAX_EDGE);
        else
            edge_n = edge_size_reg;
    end

    assign rot_eff = rot_clamp(rotation_reg);

    // Stage handshake chain
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic s1_ready, s2_ready, out_ready;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s2_ready      = !s2_valid_reg || out_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= s_axis_tvalid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (out_ready)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 1: input register
    logic [VALUE_W-1:0] s1_value_reg;
    logic [COORD_W-1:0] s1_x_reg, s1_y_reg, s1_z_reg;

    always_ff @(posedge clk)
    begin
        if (s1_ready && s_axis_tvalid)
        begin
            s1_value_reg <= s_axis_tdata[31:0];
            s1_x_reg     <= s_axis_tdata[39:32];
            s1_y_reg     <= s_axis_tdata[47:40];
            s1_z_reg     <= s_axis_tdata[55:48];
        end
    end

    // Remap, then first multiply dz*n+dy
    coord_t              coord;
    logic [PART_W:0]     part_next;

    cvr_coord_remap u_remap (
        .pos_x  (s1_x_reg),
        .pos_y  (s1_y_reg),
        .pos_z  (s1_z_reg),
        .edge_n (edge_n),
        .rot    (rot_eff),
        .coord  (coord)
    );

    assign part_next = (PART_W+1)'(coord.dz) * (PART_W+1)'(edge_n)
                     + (PART_W+1)'(coord.dy);

    // Stage 2 register
    logic [PART_W-1:0]  s2_part_reg;
    logic [COORD_W-1:0] s2_dx_reg;
    logic               s2_bad_reg;
    logic [VALUE_W-1:0] s2_value_reg;
    logic [ROT_W-1:0]   s2_rot_reg;

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_part_reg  <= part_next[PART_W-1:0];
            s2_dx_reg    <= coord.dx;
            s2_bad_reg   <= coord.bad;
            s2_value_reg <= s1_value_reg;
            s2_rot_reg   <= rot_eff;
        end
    end

    // Second multiply part*n+dx, quaternion lookup
    logic [ADDR_W:0]   addr_full;
    logic [ADDR_W-1:0] addr_next;
    quat_t             quat_next;

    assign addr_full = (ADDR_W+1)'(s2_part_reg) * (ADDR_W+1)'(edge_n)
                     + (ADDR_W+1)'(s2_dx_reg);
    assign addr_next = s2_bad_reg ? '0 : addr_full[ADDR_W-1:0];
    assign quat_next = rot_quat(s2_rot_reg);

    // Result register
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [VALUE_W-1:0] out_value_reg;
    quat_t              out_quat_reg;
    logic               out_bad_reg;

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            out_addr_reg  <= addr_next;
            out_value_reg <= s2_value_reg;
            out_quat_reg  <= quat_next;
            out_bad_reg   <= s2_bad_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_quat_reg.z, out_quat_reg.y, out_quat_reg.x,
                            out_quat_reg.w, out_value_reg, out_addr_reg};
    assign m_axis_tuser  = out_bad_reg;

`ifndef SYNTH
    // Flagged beat carries a zero address
    a_bad_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[23:0] == 24'd0))
        else $error("out_of_range beat with nonzero address");

    // Input only backpressured when every stage is full
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && s2_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // Stage 1 beat moves on when stage 2 can take it
    a_s1_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> s2_valid_reg)
        else $error("stage 1 beat dropped");
`endif

endmodule

// ----- rtl/core/cvr_coord_remap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvr_coord_remap: coordinate permutation and mirroring
// Picks and mirrors the source axes for the selected rotation and flags any
// coordinate at or beyond the edge length.
// ----------------------------------------------------------------------------
module cvr_coord_remap
    import cvr_pkg::*;
(
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_y,
    input  logic [COORD_W-1:0] pos_z,
    input  logic [EDGE_W-1:0]  edge_n,
    input  logic [ROT_W-1:0]   rot,
    output coord_t             coord
);

    axis_sel_t sel;

    // One destination axis: pick source, mirror as n-1-c if asked
    function automatic logic [COORD_W-1:0] pick(
        input axis_code_t         code,
        input logic [COORD_W-1:0] sx,
        input logic [COORD_W-1:0] sy,
        input logic [COORD_W-1:0] sz,
        input logic [EDGE_W-1:0]  n
    );
        logic [COORD_W-1:0] c;
        logic [EDGE_W-1:0]  m;
        logic [1:0]         ax;
        ax = code[1:0];
        unique case (ax)
            2'd0:    c = sx;
            2'd1:    c = sy;
            2'd2:    c = sz;
            default: c = '0;
        endcase
        m = n - EDGE_W'(1) - EDGE_W'(c);
        return code[2] ? m[COORD_W-1:0] : c;
    endfunction

    assign sel = rot_axes(rot);

    // Remap and range check
    always_comb
    begin
        coord.dx  = pick(sel.cx, pos_x, pos_y, pos_z, edge_n);
        coord.dy  = pick(sel.cy, pos_x, pos_y, pos_z, edge_n);
        coord.dz  = pick(sel.cz, pos_x, pos_y, pos_z, edge_n);
        coord.bad = (EDGE_W'(pos_x) >= edge_n) || (EDGE_W'(pos_y) >= edge_n)
                 || (EDGE_W'(pos_z) >= edge_n);
    end

endmodule
